>>> rtl/qte_pkg.sv
`timescale 1ns / 1ps
package qte_pkg;

    localparam int QUAT_W          = 32;
    localparam int ANGLE_W         = 16;
    localparam int DEF_FRAC_BITS   = 30;
    localparam int DEF_CORDIC      = 16;
    localparam int TAB_LEN         = 24;
    // Q26 working values from the multiplier stage, wide enough for any fraction width
    localparam int OP_W            = 64;
    // Q30 CORDIC datapath, normalized operands below 2^30
    localparam int CD_W            = 34;
    localparam int ANG_W           = 34;
    localparam int SQ_W            = 54;
    localparam int SQRT_W          = 27;
    localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [OP_W-1:0]  ONE_Q26 = OP_W'(64'sd1 << 26);
    localparam logic [12:0]             DEG_SCALE = 13'd5730;
    localparam logic [ANGLE_W-1:0]      ANGLE_LIMIT = 16'd18010;

    // atan(2^-i) in Q30 radians
    function automatic logic signed [ANG_W-1:0] atan_lut(input int i);
        logic signed [ANG_W-1:0] v;
        begin
            case (i)
                0: v = 34'sd843314857;
                1: v = 34'sd497837829;
                2: v = 34'sd263043837;
                3: v = 34'sd133525159;
                4: v = 34'sd67021687;
                5: v = 34'sd33543516;
                6: v = 34'sd16775851;
                7: v = 34'sd8388437;
                8: v = 34'sd4194283;
                9: v = 34'sd2097149;
                10: v = 34'sd1048576;
                11: v = 34'sd524288;
                12: v = 34'sd262144;
                13: v = 34'sd131072;
                14: v = 34'sd65536;
                15: v = 34'sd32768;
                16: v = 34'sd16384;
                17: v = 34'sd8192;
                18: v = 34'sd4096;
                19: v = 34'sd2048;
                20: v = 34'sd1024;
                21: v = 34'sd512;
                22: v = 34'sd256;
                23: v = 34'sd128;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/qte_isqrt.sv
`timescale 1ns / 1ps
// Pipelined floor square root of (1 - a^2) in Q52, one result bit per stage.
module qte_isqrt
    import qte_pkg::*;
(
    input  logic                     clk,
    input  logic                     adv,
    input  logic signed [OP_W-1:0]   arg,
    output logic [SQRT_W-1:0]        root,
    output logic signed [OP_W-1:0]   arg_out
);
    localparam int N = SQRT_W;

    logic [SQ_W-1:0]        rem_reg  [N+1];
    logic [SQRT_W-1:0]      res_reg  [N+1];
    logic signed [OP_W-1:0] a_reg    [N+1];
    logic [SQ_W-1:0]        sq_next;
    logic [OP_W-1:0]        mag_a;

    // Form 2^52 - a^2 with a clamped to [-2^26, 2^26]
    always_comb
    begin
        mag_a   = arg[OP_W-1] ? OP_W'(-arg) : OP_W'(arg);
        sq_next = SQ_W'(64'd1 << 52) - (SQ_W'(mag_a[26:0]) * SQ_W'(mag_a[26:0]));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= sq_next;
            res_reg[0] <= '0;
            a_reg[0]   <= arg;
        end
    end

    // Restoring square root: stage k decides bit N-1-k
    for (genvar k = 0; k < N; k++)
    begin : g_sq
        localparam int B = N - 1 - k;
        logic [SQ_W+1:0] trial;
        logic [SQ_W+1:0] step;
        always_comb
        begin
            trial = (SQ_W+2)'(rem_reg[k]);
            step  = ((SQ_W+2)'(res_reg[k]) << (B + 1)) | ((SQ_W+2)'(1) << (2 * B));
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_reg[k+1] <= a_reg[k];
                if (trial >= step)
                begin
                    rem_reg[k+1] <= SQ_W'(trial - step);
                    res_reg[k+1] <= res_reg[k] | (SQRT_W'(1) << B);
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    res_reg[k+1] <= res_reg[k];
                end
            end
        end
    end

    assign root    = res_reg[N];
    assign arg_out = a_reg[N];
endmodule

>>> rtl/qte_atan2.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC atan2; output angle in Q30 radians.
module qte_atan2
    import qte_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC
)
(
    input  logic                     clk,
    input  logic                     adv,
    input  logic signed [OP_W-1:0]   y_in,
    input  logic signed [OP_W-1:0]   x_in,
    output logic signed [ANG_W-1:0]  angle
);
    localparam int NS = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int SH_W = 7;

    logic signed [OP_W:0]   qx_next, qy_next;
    logic signed [ANG_W-1:0] q_z_next;
    logic                    zero_next;
    logic signed [OP_W:0]   qx_reg, qy_reg;
    logic signed [ANG_W-1:0] qz_reg;
    logic                    zero_reg;
    logic [SH_W-1:0]         lz_next;
    logic [SH_W-1:0]         sh_reg;
    logic                    dn_reg;
    logic signed [OP_W:0]   nx_reg, ny_reg;
    logic signed [ANG_W-1:0] nz_reg;
    logic [OP_W:0]           m_mag;
    logic [OP_W:0]           ax, ay;

    // Stage A: fold the left half plane
    always_comb
    begin
        zero_next = (x_in == 0) && (y_in == 0);
        if (x_in < 0)
        begin
            q_z_next = (y_in >= 0) ? PI_Q30 : -PI_Q30;
            qx_next  = -(OP_W+1)'(x_in);
            qy_next  = -(OP_W+1)'(y_in);
        end
        else
        begin
            q_z_next = '0;
            qx_next  = (OP_W+1)'(x_in);
            qy_next  = (OP_W+1)'(y_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg   <= qx_next;
            qy_reg   <= qy_next;
            qz_reg   <= q_z_next;
            zero_reg <= zero_next;
        end
    end

    // Stage B: find the normalizing shift from the larger magnitude
    always_comb
    begin
        ax = qx_reg[OP_W] ? -qx_reg : qx_reg;
        ay = qy_reg[OP_W] ? -qy_reg : qy_reg;
        m_mag = (ax > ay) ? ax : ay;
        lz_next = '0;
        for (int b = 0; b <= OP_W; b++)
        begin
            if (m_mag[b])
            begin
                lz_next = SH_W'(b);
            end
        end
    end

    logic signed [OP_W:0]    bx_reg, by_reg;
    logic signed [ANG_W-1:0] bz_reg;
    logic                    bzero_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bx_reg    <= qx_reg;
            by_reg    <= qy_reg;
            bz_reg    <= qz_reg;
            bzero_reg <= zero_reg;
            dn_reg    <= (lz_next >= SH_W'(29));
            sh_reg    <= (lz_next >= SH_W'(29)) ? lz_next - SH_W'(29) : SH_W'(29) - lz_next;
        end
    end

    // Stage C: apply the shift (arithmetic shift is floor)
    logic zero_reg_c;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg <= dn_reg ? (bx_reg >>> sh_reg) : (bx_reg <<< sh_reg);
            ny_reg <= dn_reg ? (by_reg >>> sh_reg) : (by_reg <<< sh_reg);
            nz_reg <= bz_reg;
            zero_reg_c <= bzero_reg;
        end
    end

    logic signed [CD_W-1:0]  cx_reg [NS+1];
    logic signed [CD_W-1:0]  cy_reg [NS+1];
    logic signed [ANG_W-1:0] cz_reg [NS+1];
    logic                    cz0_reg [NS+1];

    always_comb
    begin
        cx_reg[0]  = CD_W'(nx_reg);
        cy_reg[0]  = CD_W'(ny_reg);
        cz_reg[0]  = nz_reg;
        cz0_reg[0] = zero_reg_c;
    end

    // Micro-rotation stages
    for (genvar i = 0; i < NS; i++)
    begin : g_rot
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cz0_reg[i+1] <= cz0_reg[i];
                if (cy_reg[i] > 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + atan_lut(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - atan_lut(i);
                end
            end
        end
    end

    assign angle = cz0_reg[NS] ? '0 : cz_reg[NS];
endmodule

>>> rtl/qte_scale.sv
`timescale 1ns / 1ps
// Q30 radians to hundredths of a degree, two register stages.
module qte_scale
    import qte_pkg::*;
(
    input  logic                      clk,
    input  logic                      adv,
    input  logic signed [ANG_W-1:0]   angle,
    output logic signed [ANGLE_W-1:0] hund
);
    logic [ANG_W-1:0]    mag_reg;
    logic                neg_reg, neg2_reg;
    logic [ANG_W+13:0]   prod;
    logic [ANG_W+13:0]   r;
    logic [ANGLE_W-1:0]  sat_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg <= angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
            neg_reg <= angle[ANG_W-1];
        end
    end

    // Multiply, round half up, saturate
    always_comb
    begin
        prod = (ANG_W+14)'(mag_reg) * (ANG_W+14)'(DEG_SCALE);
        r    = (prod + (ANG_W+14)'(1 << 29)) >> 30;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_reg  <= (r > (ANG_W+14)'(ANGLE_LIMIT)) ? ANGLE_LIMIT : r[ANGLE_W-1:0];
            neg2_reg <= neg_reg;
        end
    end

    assign hund = neg2_reg ? -$signed(sat_reg) : $signed(sat_reg);
endmodule

>>> rtl/quaternion_to_euler_angles_unit.sv
`timescale 1ns / 1ps
// Quaternion to ZYX Euler angle converter.
// Input channel: quat_w/x/y/z (signed Q30), in_valid/in_ready.
// Output channel: pitch/roll/yaw in hundredths of a degree plus
// pitch_clamped, out_valid/out_ready.
// Throughput: one quaternion per cycle while the output is not stalled.
// The pipeline has 2 product stages, 1 square root setup stage and SQRT_W
// (27) root bit stages on the pitch path, 3 normalize stages,
// CORDIC_STAGES rotation stages (at most TAB_LEN) and 2 scale stages
// from transfer in to result valid. The pipeline is set by the
// square root and CORDIC chains.
// Roll and yaw are delayed to line up with pitch.
// Reset clears all valid bits; no item is in flight afterwards.
// When the receiver stalls the whole pipeline holds; in_ready drops
// only while the output register is full and not being taken.
module quaternion_to_euler_angles_unit
    import qte_pkg::*;
#(
    parameter int QUAT_FRAC_BITS = DEF_FRAC_BITS,
    parameter int CORDIC_STAGES  = DEF_CORDIC
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [QUAT_W-1:0]   quat_w,
    input  logic signed [QUAT_W-1:0]   quat_x,
    input  logic signed [QUAT_W-1:0]   quat_y,
    input  logic signed [QUAT_W-1:0]   quat_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [ANGLE_W-1:0]  pitch_angle,
    output logic signed [ANGLE_W-1:0]  roll_angle,
    output logic signed [ANGLE_W-1:0]  yaw_angle,
    output logic                       pitch_clamped
);
    localparam int NS  = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
    localparam int LAT = 2 + 1 + SQRT_W + 3 + NS + 2;
    localparam int S2  = 2 * QUAT_FRAC_BITS - 27;
    localparam int S1  = 2 * QUAT_FRAC_BITS - 26;

    logic adv;
    logic [LAT-1:0] vld_reg;

    // Pipeline moves when the last stage is empty or being taken
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // Stage 1: products
    logic signed [63:0] wy_reg, xz_reg, yz_reg, wx_reg, xx_reg, yy_reg, xy_reg, wz_reg,
                        ww_reg, zz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wy_reg <= quat_w * quat_y;  xz_reg <= quat_x * quat_z;
            yz_reg <= quat_y * quat_z;  wx_reg <= quat_w * quat_x;
            xx_reg <= quat_x * quat_x;  yy_reg <= quat_y * quat_y;
            xy_reg <= quat_x * quat_y;  wz_reg <= quat_w * quat_z;
            ww_reg <= quat_w * quat_w;  zz_reg <= quat_z * quat_z;
        end
    end

    // Stage 2: sums in Q26 and clamp the asin argument
    logic signed [OP_W-1:0] a_raw, a_next, ry_next, rx_next, yy_next, yx_next;
    logic signed [OP_W-1:0] a_reg, ry_reg, rx_reg, yy_reg2, yx_reg;
    logic                   clamp_next, clamp_reg;
    always_comb
    begin
        a_raw   = OP_W'(wy_reg >>> S2) - OP_W'(xz_reg >>> S2);
        ry_next = OP_W'(yz_reg >>> S2) + OP_W'(wx_reg >>> S2);
        rx_next = ONE_Q26 - OP_W'(xx_reg >>> S2) - OP_W'(yy_reg >>> S2);
        yy_next = OP_W'(xy_reg >>> S2) + OP_W'(wz_reg >>> S2);
        yx_next = OP_W'(ww_reg >>> S1) + OP_W'(xx_reg >>> S1)
                - OP_W'(yy_reg >>> S1) - OP_W'(zz_reg >>> S1);
        clamp_next = 1'b1;
        if (a_raw > ONE_Q26)
            a_next = ONE_Q26;
        else if (a_raw < -ONE_Q26)
            a_next = -ONE_Q26;
        else
        begin
            a_next     = a_raw;
            clamp_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg <= a_next;  ry_reg <= ry_next;  rx_reg <= rx_next;
            yy_reg2 <= yy_next;  yx_reg <= yx_next;  clamp_reg <= clamp_next;
        end
    end

    // Pitch: square root then atan2
    logic [SQRT_W-1:0]      root;
    logic signed [OP_W-1:0] a_dly;
    qte_isqrt u_sqrt (
        .clk(clk), .adv(adv), .arg(a_reg),
        .root(root), .arg_out(a_dly)
    );

    // Roll, yaw and flag delay to match the square root
    logic signed [OP_W-1:0] ry_d [SQRT_W+1], rx_d [SQRT_W+1];
    logic signed [OP_W-1:0] yy_d [SQRT_W+1], yx_d [SQRT_W+1];
    logic [SQRT_W:0]        cl_d;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ry_d[0] <= ry_reg;  rx_d[0] <= rx_reg;
            yy_d[0] <= yy_reg2; yx_d[0] <= yx_reg;
            for (int k = 1; k < SQRT_W + 1; k++)
            begin
                ry_d[k] <= ry_d[k-1];  rx_d[k] <= rx_d[k-1];
                yy_d[k] <= yy_d[k-1];  yx_d[k] <= yx_d[k-1];
            end
            cl_d <= {cl_d[SQRT_W-1:0], clamp_reg};
        end
    end

    logic [NS+4:0] cl_t;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cl_t <= {cl_t[NS+3:0], cl_d[SQRT_W]};
        end
    end

    logic signed [ANG_W-1:0] p_ang, r_ang, y_ang;
    qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
        .clk(clk), .adv(adv), .y_in(a_dly), .x_in(OP_W'(root)), .angle(p_ang)
    );
    qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_roll (
        .clk(clk), .adv(adv), .y_in(ry_d[SQRT_W]), .x_in(rx_d[SQRT_W]), .angle(r_ang)
    );
    qte_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
        .clk(clk), .adv(adv), .y_in(yy_d[SQRT_W]), .x_in(yx_d[SQRT_W]), .angle(y_ang)
    );

    qte_scale u_sp (.clk(clk), .adv(adv), .angle(p_ang), .hund(pitch_angle));
    qte_scale u_sr (.clk(clk), .adv(adv), .angle(r_ang), .hund(roll_angle));
    qte_scale u_sy (.clk(clk), .adv(adv), .angle(y_ang), .hund(yaw_angle));

    assign pitch_clamped = cl_t[NS+4];

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pitch_angle))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("pipeline stalled with empty output");
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_angle <= 16'sd18010) && (pitch_angle >= -16'sd18010))
        else $error("pitch out of range");
`endif
endmodule

>>> tb/tb_quaternion_to_euler_angles_unit.sv
`timescale 1ns / 1ps
module tb_quaternion_to_euler_angles_unit;
    import qte_pkg::*;

    localparam int  FRAC_BITS  = 30;
    localparam int  ROT_STAGES = 16;
    localparam int  LATENCY    = 35 + ROT_STAGES;
    localparam int  STALL_LIMIT = 20000;
    localparam longint ONE_Q26_L = 64'sd1 << 26;
    localparam longint PI_L      = 64'sd3373259426;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] yaw;
        logic                      clamped;
    } euler_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [QUAT_W-1:0] quat_w, quat_x, quat_y, quat_z;
    logic out_valid;
    logic out_ready;
    logic signed [ANGLE_W-1:0] pitch_angle, roll_angle, yaw_angle;
    logic pitch_clamped;

    euler_t angles_pending[$];
    int     error_count;
    int     quat_count;
    int     euler_count;
    int     clamp_count;
    int     idle_cycles;
    int     send_gap_pct;
    int     recv_gap_pct;

    quaternion_to_euler_angles_unit #(
        .QUAT_FRAC_BITS(FRAC_BITS),
        .CORDIC_STAGES (ROT_STAGES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .quat_w       (quat_w),
        .quat_x       (quat_x),
        .quat_y       (quat_y),
        .quat_z       (quat_z),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pitch_angle  (pitch_angle),
        .roll_angle   (roll_angle),
        .yaw_angle    (yaw_angle),
        .pitch_clamped(pitch_clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Floor division by a power of two
    function automatic longint shr_floor(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint int_sqrt(input longint unsigned d);
        longint unsigned res;
        longint unsigned bitv;
        begin
            res  = 0;
            bitv = 64'd1 << 62;
            while (bitv > d)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (d >= res + bitv)
                begin
                    d   = d - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return longint'(res);
        end
    endfunction

    // Vectoring-mode angle of (x, y) in Q30 radians
    function automatic longint vector_angle(input longint y, input longint x);
        longint acc, m, dx, dy;
        begin
            acc = 0;
            if (x == 0 && y == 0)
                return 0;
            if (x < 0)
            begin
                acc = (y >= 0) ? PI_L : -PI_L;
                x = -x;
                y = -y;
            end
            m = (x > (y < 0 ? -y : y)) ? x : (y < 0 ? -y : y);
            while (m >= (64'sd1 << 30))
            begin
                x = shr_floor(x, 1);
                y = shr_floor(y, 1);
                m = m >> 1;
            end
            while (m < (64'sd1 << 29))
            begin
                x = x * 2;
                y = y * 2;
                m = m * 2;
            end
            for (int i = 0; i < ROT_STAGES && i < TAB_LEN; i++)
            begin
                dx = shr_floor(y, i);
                dy = shr_floor(x, i);
                if (y > 0)
                begin
                    x = x + dx;
                    y = y - dy;
                    acc = acc + longint'(atan_lut(i));
                end
                else
                begin
                    x = x - dx;
                    y = y + dy;
                    acc = acc - longint'(atan_lut(i));
                end
            end
            return acc;
        end
    endfunction

    // Radians in Q30 to saturated hundredths of a degree
    function automatic logic signed [ANGLE_W-1:0] to_centideg(input longint ang);
        longint a, r;
        begin
            a = (ang < 0 ? -ang : ang) * 5730;
            r = (a + (64'sd1 << 29)) >>> 30;
            if (r > 18010)
                r = 18010;
            if (ang < 0)
                r = -r;
            return r[ANGLE_W-1:0];
        end
    endfunction

    function automatic euler_t predict_euler(input logic signed [31:0] qw,
                                             input logic signed [31:0] qx,
                                             input logic signed [31:0] qy,
                                             input logic signed [31:0] qz);
        longint w, x, y, z, a, c, ry, rx, yy, yx;
        int s2, s1;
        euler_t e;
        begin
            s2 = 2 * FRAC_BITS - 27;
            s1 = 2 * FRAC_BITS - 26;
            w = qw; x = qx; y = qy; z = qz;
            e.clamped = 1'b0;
            a = shr_floor(w * y, s2) - shr_floor(x * z, s2);
            if (a > ONE_Q26_L)
            begin
                a = ONE_Q26_L;
                e.clamped = 1'b1;
            end
            else if (a < -ONE_Q26_L)
            begin
                a = -ONE_Q26_L;
                e.clamped = 1'b1;
            end
            c  = int_sqrt(longint'(ONE_Q26_L * ONE_Q26_L - a * a));
            ry = shr_floor(y * z, s2) + shr_floor(w * x, s2);
            rx = ONE_Q26_L - shr_floor(x * x, s2) - shr_floor(y * y, s2);
            yy = shr_floor(x * y, s2) + shr_floor(w * z, s2);
            yx = shr_floor(w * w, s1) + shr_floor(x * x, s1)
               - shr_floor(y * y, s1) - shr_floor(z * z, s1);
            e.pitch = to_centideg(vector_angle(a, c));
            e.roll  = to_centideg(vector_angle(ry, rx));
            e.yaw   = to_centideg(vector_angle(yy, yx));
            return e;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("MISMATCH result %0d %s: got %0d expected %0d",
                     euler_count, what, got, want);
            error_count++;
        end
    endtask

    // Drive one quaternion and hold it until the transfer
    task automatic send_quat(input logic [31:0] qw, input logic [31:0] qx,
                             input logic [31:0] qy, input logic [31:0] qz);
        begin
            while ($urandom_range(99) < send_gap_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            quat_w   <= qw;
            quat_x   <= qx;
            quat_y   <= qy;
            quat_z   <= qz;
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            angles_pending.push_back(predict_euler(qw, qx, qy, qz));
            quat_count++;
            @(negedge clk);
        end
    endtask

    // Check each transferred result against the oldest prediction
    always @(posedge clk)
    begin
        euler_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (angles_pending.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                e = angles_pending.pop_front();
                if (pitch_angle !== e.pitch)
                    report_mismatch("pitch", pitch_angle, e.pitch);
                if (roll_angle !== e.roll)
                    report_mismatch("roll", roll_angle, e.roll);
                if (yaw_angle !== e.yaw)
                    report_mismatch("yaw", yaw_angle, e.yaw);
                if (pitch_clamped !== e.clamped)
                    report_mismatch("clamped", pitch_clamped, e.clamped);
                if (e.clamped)
                    clamp_count++;
            end
            euler_count++;
        end
    end

    // Randomize the receiver stall
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_gap_pct);

    // Watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    function automatic logic [31:0] rand_unit_comp();
        // Mostly magnitude near unit range, sometimes any pattern
        if ($urandom_range(9) < 2)
            return $urandom;
        return $signed($urandom_range(32'h4000_0000)) * ($urandom_range(1) ? 1 : -1);
    endfunction

    task automatic test_directed();
        logic [31:0] one_q, half_q;
        begin
            one_q  = 32'h4000_0000;
            half_q = 32'h2000_0000;
            send_quat(one_q, 0, 0, 0);
            send_quat(0, 0, 0, 0);
            send_quat(half_q, half_q, half_q, half_q);
            send_quat(half_q, -half_q, half_q, half_q);
            // Gimbal lock, both signs
            send_quat(32'h2D41_3CCD, 0, 32'h2D41_3CCD, 0);
            send_quat(32'h2D41_3CCD, 0, 32'hD2BE_C333, 0);
            // Asin argument out of range
            send_quat(one_q, 0, one_q, 0);
            send_quat(one_q, 0, -one_q, 0);
            // Negative x operand with zero y: angle is pi
            send_quat(0, one_q, 0, 0);
            send_quat(0, 0, 0, one_q);
            send_quat(0, 0, one_q, 0);
            // Extremes of the field range
            send_quat(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
            send_quat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            send_quat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
            send_quat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
            send_quat(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
            send_quat(-one_q, 0, 0, 0);
            send_quat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        end
    endtask

    task automatic test_random(input int count, input int s_pct, input int r_pct);
        begin
            send_gap_pct = s_pct;
            recv_gap_pct = r_pct;
            repeat (count)
                send_quat(rand_unit_comp(), rand_unit_comp(),
                          rand_unit_comp(), rand_unit_comp());
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        out_ready    = 1'b0;
        quat_w       = '0;
        quat_x       = '0;
        quat_y       = '0;
        quat_z       = '0;
        error_count  = 0;
        quat_count   = 0;
        euler_count  = 0;
        clamp_count  = 0;
        send_gap_pct = 11;
        recv_gap_pct = 60;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(700, 11, 60);
        test_random(700, 60, 11);
        test_random(600, 0, 0);
        in_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (angles_pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("Sent %0d quaternions, checked %0d angle sets (%0d with clamped pitch).",
                 quat_count, euler_count, clamp_count);
        $display("Covered unit, zero, gimbal-lock, out-of-range and full-scale inputs.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
